>>> hdl/phist_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and action codes for the per-channel pixel histogram.
// No dependencies; imported by the core, the divider and the checker and testbench.
package phist_pkg;

   // Geometry of the histogram store
   localparam int MaxChannels = 4;
   localparam int BinCount    = 256;
   localparam int ChanWidth   = $clog2(MaxChannels);
   localparam int BinWidth    = $clog2(BinCount);
   localparam int StoreDepth  = MaxChannels * BinCount;
   localparam int AddrWidth   = $clog2(StoreDepth);

   // Count and fraction widths
   localparam int CountWidth  = 23;
   localparam int FracWidth   = 16;
   localparam int CfgWidth    = 3;

   localparam logic [CountWidth-1:0] MaxPixels   = CountWidth'(4194304);
   localparam logic [CfgWidth-1:0]   ChanLimit   = CfgWidth'(MaxChannels);
   localparam logic [CfgWidth-1:0]   ChanMin     = CfgWidth'(1);
   localparam logic [CfgWidth-1:0]   ChanDefault = CfgWidth'(3);

   // Action codes
   localparam logic [1:0] ActAdd   = 2'd0;
   localparam logic [1:0] ActRead  = 2'd1;
   localparam logic [1:0] ActClear = 2'd2;

   typedef struct packed {
      logic [1:0]           action;
      logic [BinWidth-1:0]  sample0;
      logic [BinWidth-1:0]  sample1;
      logic [BinWidth-1:0]  sample2;
      logic [BinWidth-1:0]  sample3;
      logic [ChanWidth-1:0] read_channel;
      logic [BinWidth-1:0]  read_bin;
   } req_type;

   typedef struct packed {
      logic [FracWidth-1:0]  frequency;
      logic [CountWidth-1:0] bin_count;
      logic [CountWidth-1:0] pixel_total;
      logic                  overflow;
   } rsp_type;

endpackage

>>> hdl/per_channel_pixel_histogram_core.sv
`timescale 1ns / 1ps
// Per-channel 256-bin pixel histogram: bin store in one 1024 x 23 RAM, read-modify-write.
// Add: one RAM read and one write per channel (n active channels).
// Read: the strobe follows the RAM read and the divide (16 divider steps), which is skipped
// when the total is zero or the bin holds every pixel. Clear: one entry zeroed per cycle.
// The same pass runs after reset, with busy high throughout. Results cannot be stalled.
// Depends on phist_pkg, phist_ram and phist_div.
module per_channel_pixel_histogram_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  phist_pkg::req_type             req_item,
   output logic                           rsp_strobe,
   output phist_pkg::rsp_type             rsp_item,
   input  logic                           csr_wr_en,
   input  logic [phist_pkg::CfgWidth-1:0] csr_wr_data
);

   import phist_pkg::*;

   typedef enum logic [2:0] {
      StClear,
      StIdle,
      StAdd,
      StRdIssue,
      StRdData,
      StDiv
   } state_type;

   state_type              state_ff, state_in;
   logic [CfgWidth-1:0]    chan_cfg_ff;
   logic [CfgWidth-1:0]    active_n;
   logic [CfgWidth-1:0]    n_ff, n_in;
   logic [CfgWidth-1:0]    rd_ch_ff, rd_ch_in;
   logic                   wr_pend_ff, wr_pend_in;
   logic [AddrWidth-1:0]   wr_addr_ff, wr_addr_in;
   logic [AddrWidth-1:0]   rd_addr_ff, rd_addr_in;
   logic [AddrWidth-1:0]   clr_addr_ff, clr_addr_in;
   logic                   rc_ok_ff, rc_ok_in;
   logic [CountWidth-1:0]  pix_ff, pix_in;
   logic                   flag_ff, flag_in;
   logic [CountWidth-1:0]  cnt_ff, cnt_in;
   logic [BinWidth-1:0]    sample_ff [MaxChannels];
   logic [BinWidth-1:0]    sample_in [MaxChannels];
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   mem_we, mem_re;
   logic [AddrWidth-1:0]   mem_waddr, mem_raddr;
   logic [CountWidth-1:0]  mem_wdata, mem_rdata;
   logic                   bin_full;

   logic                   div_start, div_done;
   logic [FracWidth-1:0]   div_quo;

   logic                   accept;
   logic [ChanWidth-1:0]   rd_ch_idx;

   // Channel count register
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cfg_ff <= ChanDefault;
      end else if (csr_wr_en) begin
         chan_cfg_ff <= csr_wr_data;
      end
   end

   // Clamp the channel count into 1..MaxChannels
   always_comb begin
      active_n = chan_cfg_ff;
      if (chan_cfg_ff < ChanMin) begin
         active_n = ChanMin;
      end else if (chan_cfg_ff > ChanLimit) begin
         active_n = ChanLimit;
      end
   end

   assign accept    = start && (state_ff == StIdle);
   assign rd_ch_idx = rd_ch_ff[ChanWidth-1:0];
   assign bin_full  = mem_rdata >= MaxPixels;

   // Sequencer: add, read and clear passes over the bin store
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      rd_ch_in      = rd_ch_ff;
      wr_pend_in    = wr_pend_ff;
      wr_addr_in    = wr_addr_ff;
      rd_addr_in    = rd_addr_ff;
      clr_addr_in   = clr_addr_ff;
      rc_ok_in      = rc_ok_ff;
      pix_in        = pix_ff;
      flag_in       = flag_ff;
      cnt_in        = cnt_ff;
      sample_in     = sample_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = wr_addr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = rd_addr_ff;
      div_start     = 1'b0;
      case (state_ff)
         StClear: begin
            // Zero one entry per cycle
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (accept) begin
               case (req_item.action)
                  ActAdd: begin
                     sample_in[0] = req_item.sample0;
                     sample_in[1] = req_item.sample1;
                     sample_in[2] = req_item.sample2;
                     sample_in[3] = req_item.sample3;
                     n_in         = active_n;
                     rd_ch_in     = '0;
                     wr_pend_in   = 1'b0;
                     // Count the pixel, hold at the limit
                     if (pix_ff < MaxPixels) begin
                        pix_in = pix_ff + 1'b1;
                     end else begin
                        flag_in = 1'b1;
                     end
                     state_in = StAdd;
                  end
                  ActRead: begin
                     rd_addr_in = {req_item.read_channel, req_item.read_bin};
                     rc_ok_in   = {1'b0, req_item.read_channel} < ChanLimit;
                     state_in   = StRdIssue;
                  end
                  ActClear: begin
                     clr_addr_in = '0;
                     pix_in      = '0;
                     flag_in     = 1'b0;
                     state_in    = StClear;
                  end
                  default: begin
                     state_in = StIdle;
                  end
               endcase
            end
         end
         StAdd: begin
            // Write back the bin read in the previous cycle
            if (wr_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               if (bin_full) begin
                  mem_wdata = mem_rdata;
                  flag_in   = 1'b1;
               end else begin
                  mem_wdata = mem_rdata + 1'b1;
               end
            end
            // Issue the read of the next channel's bin
            if (rd_ch_ff < n_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = {rd_ch_idx, sample_ff[rd_ch_idx]};
               wr_addr_in = {rd_ch_idx, sample_ff[rd_ch_idx]};
               wr_pend_in = 1'b1;
               rd_ch_in   = rd_ch_ff + 1'b1;
            end else begin
               wr_pend_in = 1'b0;
               state_in   = StIdle;
            end
         end
         StRdIssue: begin
            mem_re    = 1'b1;
            mem_raddr = rd_addr_ff;
            state_in  = StRdData;
         end
         StRdData: begin
            cnt_in    = rc_ok_ff ? mem_rdata : '0;
            div_start = 1'b1;
            state_in  = StDiv;
         end
         StDiv: begin
            if (div_done) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.frequency   = div_quo;
               rsp_in.bin_count   = cnt_ff;
               rsp_in.pixel_total = pix_ff;
               rsp_in.overflow    = flag_ff;
               state_in           = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StClear;
         clr_addr_ff   <= '0;
         rd_ch_ff      <= '0;
         wr_pend_ff    <= 1'b0;
         pix_ff        <= '0;
         flag_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rd_ch_ff      <= rd_ch_in;
         wr_pend_ff    <= wr_pend_in;
         pix_ff        <= pix_in;
         flag_ff       <= flag_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      n_ff       <= n_in;
      wr_addr_ff <= wr_addr_in;
      rd_addr_ff <= rd_addr_in;
      rc_ok_ff   <= rc_ok_in;
      cnt_ff     <= cnt_in;
      sample_ff  <= sample_in;
      rsp_ff     <= rsp_in;
   end

   phist_ram #(
      .Width (CountWidth),
      .Depth (StoreDepth)
   ) u_bins (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   phist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cnt_in),
      .divisor  (pix_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign busy       = (state_ff != StIdle);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   // A read passes through the issue, data and divide states, so strobes never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe high on consecutive cycles");

   // An accepted add, read or clear always makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (accept && ((req_item.action == ActAdd) || (req_item.action == ActRead) ||
                  (req_item.action == ActClear))) |=> busy)
      else $error("busy not raised after accept");

   // No result during a clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StClear) |-> !rsp_strobe)
      else $error("result during clear");

   // Pixel total never passes its limit
   assert property (@(posedge clock) disable iff (reset)
      pix_ff <= MaxPixels)
      else $error("pixel total above limit");

   // Empty histogram reports zero frequency
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.pixel_total == '0)) |-> (rsp_item.frequency == '0))
      else $error("non-zero frequency with empty histogram");
`endif

endmodule

>>> hdl/phist_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependencies.
module phist_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/phist_div.sv
`timescale 1ns / 1ps
// Restoring divider for the Q0.16 frequency: count * 65536 / total, saturated.
// Depends on phist_pkg for widths; one quotient bit per cycle.
module phist_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [phist_pkg::CountWidth-1:0] dividend,
   input  logic [phist_pkg::CountWidth-1:0] divisor,
   output logic                             done,
   output logic [phist_pkg::FracWidth-1:0]  quotient
);

   import phist_pkg::*;

   localparam int StepWidth = $clog2(FracWidth);
   localparam logic [StepWidth-1:0] LastStep = StepWidth'(FracWidth - 1);

   typedef enum logic {
      DvIdle,
      DvRun
   } dv_state_type;

   dv_state_type           state_ff, state_in;
   logic [CountWidth-1:0]  rem_ff, rem_in;
   logic [CountWidth-1:0]  div_ff, div_in;
   logic [FracWidth-1:0]   quo_ff, quo_in;
   logic [StepWidth-1:0]   step_ff, step_in;
   logic                   done_ff, done_in;
   logic [CountWidth:0]    shifted;
   logic [CountWidth:0]    diff;
   logic                   fits;

   // One restoring step: double the remainder and try the divisor
   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      case (state_ff)
         DvIdle: begin
            if (start) begin
               // Empty histogram gives zero, a full bin saturates
               if (divisor == '0) begin
                  quo_in  = '0;
                  done_in = 1'b1;
               end else if (dividend >= divisor) begin
                  quo_in  = '1;
                  done_in = 1'b1;
               end else begin
                  rem_in   = dividend;
                  div_in   = divisor;
                  quo_in   = '0;
                  step_in  = '0;
                  state_in = DvRun;
               end
            end
         end
         DvRun: begin
            if (fits) begin
               rem_in = diff[CountWidth-1:0];
            end else begin
               rem_in = shifted[CountWidth-1:0];
            end
            quo_in  = {quo_ff[FracWidth-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == LastStep) begin
               done_in  = 1'b1;
               state_in = DvIdle;
            end
         end
         default: begin
            state_in = DvIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DvIdle;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> tb/phist_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the per-channel pixel histogram: watches the item, result and csr ports,
// keeps its own copy of the bin store and checks every read result in arrival order.
// Depends on phist_pkg.
module phist_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  phist_pkg::req_type             req_item,
   input  logic                           rsp_strobe,
   input  phist_pkg::rsp_type             rsp_item,
   input  logic                           csr_wr_en,
   input  logic [phist_pkg::CfgWidth-1:0] csr_wr_data,
   output int                             failures,
   output int                             outstanding
);

   import phist_pkg::*;

   // Shadow histogram state
   logic [CountWidth-1:0] bin_store [StoreDepth];
   logic [CountWidth-1:0] total_seen;
   logic                  sat_seen;
   logic [CfgWidth-1:0]   chan_setting;
   rsp_type               reads_due [$];
   int                    error_count = 0;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   function automatic void clear_histogram();
      for (int i = 0; i < StoreDepth; i++) begin
         bin_store[i] = '0;
      end
      total_seen = '0;
      sat_seen   = 1'b0;
   endfunction

   // Hold a count at the pixel limit and flag the lost increment
   function automatic logic [CountWidth-1:0] bumped(input logic [CountWidth-1:0] count);
      if (count < MaxPixels) begin
         return count + 1'b1;
      end
      sat_seen = 1'b1;
      return count;
   endfunction

   function automatic void add_pixel(input req_type item);
      logic [BinWidth-1:0] samples [MaxChannels];
      int                  active;
      int                  addr;
      samples = '{item.sample0, item.sample1, item.sample2, item.sample3};
      // Out-of-range settings clamp to 1..MaxChannels
      active = int'(chan_setting);
      if (active < 1) begin
         active = 1;
      end
      if (active > MaxChannels) begin
         active = MaxChannels;
      end
      for (int ch = 0; ch < active; ch++) begin
         addr = ch * BinCount + int'(samples[ch]);
         bin_store[addr] = bumped(bin_store[addr]);
      end
      total_seen = bumped(total_seen);
   endfunction

   function automatic rsp_type predict_read(input req_type item);
      rsp_type             res;
      logic [63:0]         scaled;
      logic [CountWidth-1:0] count;
      count = '0;
      if (int'(item.read_channel) < MaxChannels) begin
         count = bin_store[int'(item.read_channel) * BinCount + int'(item.read_bin)];
      end
      // Empty histogram reads as zero frequency; a full bin clips to the top code
      scaled = '0;
      if (total_seen != '0) begin
         scaled = (64'(count) << FracWidth) / 64'(total_seen);
         if (scaled > 64'hFFFF) begin
            scaled = 64'hFFFF;
         end
      end
      res.frequency   = scaled[FracWidth-1:0];
      res.bin_count   = count;
      res.pixel_total = total_seen;
      res.overflow    = sat_seen;
      return res;
   endfunction

   // Compare results first, then take the accepted item and the csr write
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_histogram();
         chan_setting = ChanDefault;
         reads_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (reads_due.size() == 0) begin
               report_mismatch($sformatf("result with no read pending: %p", rsp_item));
            end else begin
               want = reads_due.pop_front();
               if (rsp_item.frequency !== want.frequency) begin
                  report_mismatch($sformatf("frequency: expected %0d, got %0d",
                                            want.frequency, rsp_item.frequency));
               end
               if (rsp_item.bin_count !== want.bin_count) begin
                  report_mismatch($sformatf("bin_count: expected %0d, got %0d",
                                            want.bin_count, rsp_item.bin_count));
               end
               if (rsp_item.pixel_total !== want.pixel_total) begin
                  report_mismatch($sformatf("pixel_total: expected %0d, got %0d",
                                            want.pixel_total, rsp_item.pixel_total));
               end
               if (rsp_item.overflow !== want.overflow) begin
                  report_mismatch($sformatf("overflow: expected %0b, got %0b",
                                            want.overflow, rsp_item.overflow));
               end
            end
         end
         if (start && !busy) begin
            case (req_item.action)
               ActAdd: begin
                  add_pixel(req_item);
               end
               ActRead: begin
                  reads_due.push_back(predict_read(req_item));
               end
               ActClear: begin
                  clear_histogram();
               end
               default: begin
               end
            endcase
         end
         if (csr_wr_en) begin
            chan_setting = csr_wr_data;
         end
      end
      failures    <= error_count;
      outstanding <= reads_due.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the histogram testbench: clock, reset, item and csr stimulus, watchdog and verdict.
// Depends on phist_pkg, per_channel_pixel_histogram_core and phist_checker.
module tb;
   import phist_pkg::*;

   localparam logic [1:0] ActUnused     = 2'd3;
   localparam int         DrainCycles   = 1100;
   localparam int         WatchdogLimit = 20000;
   localparam int         ItemsPerPhase = 66;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic                busy;
   req_type             req_item    = '0;
   logic                rsp_strobe;
   rsp_type             rsp_item;
   logic                csr_wr_en   = 1'b0;
   logic [CfgWidth-1:0] csr_wr_data = '0;
   int                  failures;
   int                  outstanding;
   int                  quiet_cycles = 0;

   // Settings per phase, extremes and out-of-range values among them
   logic [CfgWidth-1:0] cfg_plan [8] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd5, 3'd6, 3'd3};
   // Sender idle percentage per phase; the result side cannot stall
   int                  idle_plan [4] = '{0, 49, 0, 13};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   per_channel_pixel_histogram_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   phist_checker chk (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_item(input logic [1:0] act,
                                         input logic [7:0] s0, s1, s2, s3,
                                         input logic [1:0] chan, input logic [7:0] bin);
      req_type item;
      item.action       = act;
      item.sample0      = s0;
      item.sample1      = s1;
      item.sample2      = s2;
      item.sample3      = s3;
      item.read_channel = chan;
      item.read_bin     = bin;
      return item;
   endfunction

   // Favour a few low bins so reads find counts worth dividing
   function automatic logic [7:0] pick_value();
      if ($urandom_range(1) == 0) begin
         return 8'($urandom_range(7));
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic req_type random_item();
      int         roll;
      logic [1:0] act;
      roll = $urandom_range(99);
      if (roll < 60) begin
         act = ActAdd;
      end else if (roll < 93) begin
         act = ActRead;
      end else if (roll < 95) begin
         act = ActClear;
      end else begin
         act = ActUnused;
      end
      return make_item(act, pick_value(), pick_value(), pick_value(), pick_value(),
                       2'($urandom_range(3)), pick_value());
   endfunction

   // Present one item, idling first at the given rate, and hold it until accepted
   task automatic send_item(input req_type item, input int idle_pct);
      while (int'($urandom_range(99)) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // Write the register only once the block has drained
   task automatic write_channels(input logic [CfgWidth-1:0] value);
      start <= 1'b0;
      repeat (DrainCycles) @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty, full bin, inactive channel, ignored code, clear
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00), 0);
      send_item(make_item(ActUnused, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 8'hFF), 0);
      send_item(make_item(ActAdd, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00), 0);
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00), 0);
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd3, 8'h00), 0);
      send_item(make_item(ActAdd, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd0, 8'h00), 0);
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd1, 8'hFF), 0);
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd2, 8'h00), 0);
      send_item(make_item(ActAdd, 8'h55, 8'hAA, 8'h55, 8'hAA, 2'd0, 8'h00), 0);
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd1, 8'hAA), 0);
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd3, 8'hAA), 0);
      send_item(make_item(ActRead, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd0, 8'h55), 0);
      send_item(make_item(ActClear, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00), 0);
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00), 0);
      send_item(make_item(ActAdd, 8'hAA, 8'h55, 8'hAA, 8'h55, 2'd0, 8'h00), 0);
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'hAA), 0);
      send_item(make_item(ActRead, 8'h00, 8'h00, 8'h00, 8'h00, 2'd2, 8'hAA), 0);

      // Random phases, one register setting and idling pattern each
      for (int phase = 0; phase < 8; phase++) begin
         write_channels(cfg_plan[phase]);
         repeat (ItemsPerPhase) begin
            send_item(random_item(), idle_plan[phase % 4]);
         end
      end

      // Drain and give the verdict
      start <= 1'b0;
      repeat (DrainCycles) @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/phist_pkg.sv
hdl/phist_ram.sv
hdl/phist_div.sv
hdl/per_channel_pixel_histogram_core.sv
tb/phist_checker.sv
tb/tb.sv
